@@ rtl/core/fmqd_pkg.sv @@
// Package for the FM quadrature discriminator.
// Holds fixed-point constants, sequencer control structs and the CORDIC
// arctangent table. No dependencies.
`default_nettype none

package fmqd_pkg;

  // default field widths
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int PHASE_WIDTH_DEF  = 16;

  // angle accumulator: 2^TURN_BITS per full turn
  localparam int TURN_BITS    = 32;
  localparam int CORDIC_STEPS = 32;
  localparam int CORDIC_IDX_W = $clog2(CORDIC_STEPS);

  // normalised vector lies in [2^(NORM_BITS-1), 2^NORM_BITS)
  localparam int NORM_BITS = 40;

  // normaliser step index: coarse steps then one final right shift
  localparam int NORM_IDX_W  = 3;
  localparam int NORM_COARSE = 6;

  // sequencer counter and last counts of each phase
  localparam int                  CNT_W     = 5;
  localparam logic [CNT_W-1:0]    MUL_LAST  = CNT_W'(3);
  localparam logic [CNT_W-1:0]    NORM_LAST = CNT_W'(NORM_COARSE + 1);
  localparam logic [CNT_W-1:0]    ROT_LAST  = CNT_W'(CORDIC_STEPS - 1);

  // complex multiply steps, one partial product each
  typedef enum logic [1:0] {
    MS_RE_II = 2'd0,  // re  = ci * pi
    MS_RE_QQ = 2'd1,  // re += cq * pq
    MS_IM_QI = 2'd2,  // im  = cq * pi
    MS_IM_IQ = 2'd3   // im -= ci * pq
  } mul_step_t;

  typedef struct packed {
    logic                  load;
    logic                  step;
    logic [NORM_IDX_W-1:0] idx;
  } norm_ctl_t;

  typedef struct packed {
    logic                    en;
    logic                    first;
    logic [CORDIC_IDX_W-1:0] k;
  } cordic_ctl_t;

  // arctan(2^-k), 2^32 per turn, rounded to nearest
  function automatic logic [TURN_BITS-1:0] atan_entry(input logic [CORDIC_IDX_W-1:0] k);
    logic [TURN_BITS-1:0] v;
    case (k)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      5'd29:   v = 32'h00000001;
      5'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/fmqd_cmul.sv @@
// Complex multiply by the conjugate of the previous sample.
// One shared multiplier, four partial products, one per step.
// Depends on fmqd_pkg.
`default_nettype none

module fmqd_cmul #(
  parameter int SAMPLE_WIDTH = fmqd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  fmqd_pkg::mul_step_t           step,
  input  logic signed [SAMPLE_WIDTH-1:0] cur_i,
  input  logic signed [SAMPLE_WIDTH-1:0] cur_q,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_i,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_q,
  output logic signed [2*SAMPLE_WIDTH:0] re,
  output logic signed [2*SAMPLE_WIDTH:0] im
);
  import fmqd_pkg::*;

  localparam int ACC_W = 2 * SAMPLE_WIDTH + 1;

  logic signed [SAMPLE_WIDTH-1:0]   op_a;
  logic signed [SAMPLE_WIDTH-1:0]   op_b;
  logic signed [2*SAMPLE_WIDTH-1:0] prod;

  // operand select per step
  always_comb begin
    case (step)
      MS_RE_II: begin op_a = cur_i; op_b = prev_i; end
      MS_RE_QQ: begin op_a = cur_q; op_b = prev_q; end
      MS_IM_QI: begin op_a = cur_q; op_b = prev_i; end
      MS_IM_IQ: begin op_a = cur_i; op_b = prev_q; end
      default:  begin op_a = cur_i; op_b = prev_i; end
    endcase
  end

  assign prod = op_a * op_b;

  // accumulate into real and imaginary parts
  always_ff @(posedge clk) begin
    if (en) begin
      case (step)
        MS_RE_II: re <= ACC_W'(prod);
        MS_RE_QQ: re <= re + ACC_W'(prod);
        MS_IM_QI: im <= ACC_W'(prod);
        MS_IM_IQ: im <= im - ACC_W'(prod);
        default:  re <= re;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fmqd_norm.sv @@
// Block-floating normaliser for the product magnitudes.
// Binary shift search, one compare and shift per cycle while step is set; depends on fmqd_pkg.
`default_nettype none

module fmqd_norm #(
  parameter int SAMPLE_WIDTH = fmqd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  fmqd_pkg::norm_ctl_t                 ctl,
  input  logic [2*SAMPLE_WIDTH-1:0]           mag_re,
  input  logic [2*SAMPLE_WIDTH-1:0]           mag_im,
  output logic [fmqd_pkg::NORM_BITS-1:0]      norm_x,
  output logic [fmqd_pkg::NORM_BITS-1:0]      norm_y
);
  import fmqd_pkg::*;

  localparam int MAG_W = (2 * SAMPLE_WIDTH > NORM_BITS) ? 2 * SAMPLE_WIDTH : NORM_BITS;

  logic [MAG_W-1:0] x;
  logic [MAG_W-1:0] y;
  logic             go_right;

  logic [MAG_W-1:0] or_v;
  logic [MAG_W-1:0] ld_or;
  logic [5:0]       sh;
  logic [6:0]       lim;
  logic             do_shift;

  assign or_v  = x | y;
  assign ld_or = MAG_W'(mag_re) | MAG_W'(mag_im);
  assign sh    = 6'd32 >> ctl.idx;
  assign lim   = 7'(NORM_BITS) - 7'(sh);

  // shift decision: bit length of x|y equals that of max(x, y)
  always_comb begin
    if (ctl.idx == NORM_IDX_W'(NORM_COARSE)) begin
      do_shift = go_right;
    end else if (go_right) begin
      do_shift = ((or_v >> sh) >> NORM_BITS) != '0;
    end else begin
      do_shift = (or_v >> lim) == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x        <= MAG_W'(mag_re);
      y        <= MAG_W'(mag_im);
      go_right <= (ld_or >> NORM_BITS) != '0;
    end else if (ctl.step && do_shift) begin
      if (ctl.idx == NORM_IDX_W'(NORM_COARSE)) begin
        x <= x >> 1;
        y <= y >> 1;
      end else if (go_right) begin
        x <= x >> sh;
        y <= y >> sh;
      end else begin
        x <= x << sh;
        y <= y << sh;
      end
    end
  end

  assign norm_x = x[NORM_BITS-1:0];
  assign norm_y = y[NORM_BITS-1:0];

endmodule

`default_nettype wire

@@ rtl/core/fmqd_cordic.sv @@
// Vectoring CORDIC, one micro-rotation per cycle while enabled.
// Shared add/subtract and shift datapath; depends on fmqd_pkg.
`default_nettype none

module fmqd_cordic (
  input  logic                                  clk,
  input  fmqd_pkg::cordic_ctl_t                 ctl,
  input  logic [fmqd_pkg::NORM_BITS-1:0]        norm_x,
  input  logic [fmqd_pkg::NORM_BITS-1:0]        norm_y,
  output logic signed [fmqd_pkg::TURN_BITS+1:0] angle
);
  import fmqd_pkg::*;

  // headroom for CORDIC gain and sign of y
  localparam int XY_W = NORM_BITS + 3;
  localparam int Z_W  = TURN_BITS + 2;

  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [Z_W-1:0]  z;

  logic signed [XY_W-1:0] x_cur;
  logic signed [XY_W-1:0] y_cur;
  logic signed [Z_W-1:0]  z_cur;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  dz;

  // first rotation takes the normalised vector straight in
  assign x_cur = ctl.first ? $signed({3'b000, norm_x}) : x;
  assign y_cur = ctl.first ? $signed({3'b000, norm_y}) : y;
  assign z_cur = ctl.first ? '0 : z;
  assign dx    = y_cur >>> ctl.k;
  assign dy    = x_cur >>> ctl.k;
  assign dz    = $signed({2'b00, atan_entry(ctl.k)});

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (!y_cur[XY_W-1]) begin
        x <= x_cur + dx;
        y <= y_cur - dy;
        z <= z_cur + dz;
      end else begin
        x <= x_cur - dx;
        y <= y_cur + dy;
        z <= z_cur - dz;
      end
    end
  end

  assign angle = z;

endmodule

`default_nettype wire

@@ rtl/core/fm_quadrature_discriminator.sv @@
// FM quadrature discriminator: angle of current sample times conj(previous).
// Sequence per input beat: complex multiply, normalise, CORDIC rotation, finish;
// no new beat is taken until the sequencer is back in idle after the finish.
// A new input beat is taken while a finished result still waits at the output.
// Synchronous reset clears the sequencer, output valid and the previous sample.
`default_nettype none

module fm_quadrature_discriminator #(
  parameter int SAMPLE_WIDTH = fmqd_pkg::SAMPLE_WIDTH_DEF,
  parameter int PHASE_WIDTH  = fmqd_pkg::PHASE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_q,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [PHASE_WIDTH-1:0]  phase_delta
);
  import fmqd_pkg::*;

  localparam int ACC_W = 2 * SAMPLE_WIDTH + 1;
  localparam int ANG_W = TURN_BITS + 3;

  localparam logic signed [ANG_W-1:0] ANG_ONE = ANG_W'(1);
  localparam logic signed [ANG_W-1:0] ANG_PI  = ANG_ONE <<< (TURN_BITS - 1);
  localparam logic signed [ANG_W-1:0] ANG_QTR = ANG_ONE <<< (TURN_BITS - 2);
  localparam logic signed [ANG_W-1:0] ANG_RND = ANG_ONE <<< (TURN_BITS - PHASE_WIDTH - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_NORM = 5'b00100,
    S_ROT  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  logic signed [SAMPLE_WIDTH-1:0] cur_i;
  logic signed [SAMPLE_WIDTH-1:0] cur_q;
  logic signed [SAMPLE_WIDTH-1:0] last_i;
  logic signed [SAMPLE_WIDTH-1:0] last_q;

  logic signed [ACC_W-1:0]          re;
  logic signed [ACC_W-1:0]          im;
  logic [ACC_W-1:0]                 re_abs;
  logic [ACC_W-1:0]                 im_abs;
  logic [NORM_BITS-1:0]             norm_x;
  logic [NORM_BITS-1:0]             norm_y;
  logic signed [TURN_BITS+1:0]      z;
  norm_ctl_t                        nctl;
  cordic_ctl_t                      cctl;

  logic                    in_beat;
  logic                    finish;
  logic signed [ANG_W-1:0] quad;
  logic signed [ANG_W-1:0] ang;
  logic signed [ANG_W-1:0] rnd;

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign finish   = (state == S_DONE) && (!out_valid || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (in_valid) state <= S_MUL;
        end
        S_MUL: begin
          cnt <= (cnt == MUL_LAST) ? '0 : cnt + 1'b1;
          if (cnt == MUL_LAST) state <= S_NORM;
        end
        S_NORM: begin
          cnt <= (cnt == NORM_LAST) ? '0 : cnt + 1'b1;
          if (cnt == NORM_LAST) state <= S_ROT;
        end
        S_ROT: begin
          cnt <= (cnt == ROT_LAST) ? '0 : cnt + 1'b1;
          if (cnt == ROT_LAST) state <= S_DONE;
        end
        S_DONE: begin
          cnt <= '0;
          if (finish) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
          cnt   <= '0;
        end
      endcase
    end
  end

  // current sample capture and previous-sample state
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cur_i <= in_i;
      cur_q <= in_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_i <= '0;
      last_q <= '0;
    end else if (finish) begin
      last_i <= cur_i;
      last_q <= cur_q;
    end
  end

  fmqd_cmul #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_cmul (
    .clk   (clk),
    .en    (state == S_MUL),
    .step  (mul_step_t'(cnt[1:0])),
    .cur_i (cur_i),
    .cur_q (cur_q),
    .prev_i(last_i),
    .prev_q(last_q),
    .re    (re),
    .im    (im)
  );

  // magnitudes of the product parts
  assign re_abs = re[ACC_W-1] ? (~re + 1'b1) : re;
  assign im_abs = im[ACC_W-1] ? (~im + 1'b1) : im;

  always_comb begin
    nctl.load = (state == S_NORM) && (cnt == '0);
    nctl.step = (state == S_NORM) && (cnt != '0);
    nctl.idx  = NORM_IDX_W'(cnt - 1'b1);
  end

  fmqd_norm #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_norm (
    .clk   (clk),
    .ctl   (nctl),
    .mag_re(re_abs[2*SAMPLE_WIDTH-1:0]),
    .mag_im(im_abs[2*SAMPLE_WIDTH-1:0]),
    .norm_x(norm_x),
    .norm_y(norm_y)
  );

  always_comb begin
    cctl.en    = (state == S_ROT);
    cctl.first = (cnt == '0);
    cctl.k     = cnt[CORDIC_IDX_W-1:0];
  end

  fmqd_cordic u_cordic (
    .clk   (clk),
    .ctl   (cctl),
    .norm_x(norm_x),
    .norm_y(norm_y),
    .angle (z)
  );

  // quadrant fold-out; pure real and pure imaginary take exact angles
  always_comb begin
    if (im == '0)      quad = '0;
    else if (re == '0) quad = ANG_QTR;
    else               quad = ANG_W'(z);
    case ({re[ACC_W-1], im[ACC_W-1]})
      2'b10:   ang = ANG_PI - quad;
      2'b11:   ang = quad - ANG_PI;
      2'b01:   ang = -quad;
      default: ang = quad;
    endcase
    if (re == '0 && im == '0) ang = '0;
    rnd = (ang + ANG_RND) >>> (TURN_BITS - PHASE_WIDTH);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) phase_delta <= rnd[PHASE_WIDTH-1:0];
  end

  // checks
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("output valid rose outside finish");

  a_beat_starts_mul: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == S_MUL) && (cnt == '0))
    else $error("input beat did not start multiply");

  a_rot_after_norm: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT) && (cnt == '0) |-> $past(state == S_NORM) && $past(cnt == NORM_LAST))
    else $error("CORDIC started without full normalisation");

  a_no_stall_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pending result dropped");

endmodule

`default_nettype wire

@@ sim/tb_fm_quadrature_discriminator.sv @@
// Self-checking testbench for fm_quadrature_discriminator.
// Predicts each phase_delta with a bit-exact fixed-point CORDIC and checks every beat.
// Depends on fmqd_pkg and the fm_quadrature_discriminator RTL.
`timescale 1ns / 100ps

module tb_fm_quadrature_discriminator;
  import fmqd_pkg::*;

  localparam int SAMPLE_W = SAMPLE_WIDTH_DEF;
  localparam int PHASE_W  = PHASE_WIDTH_DEF;

  localparam longint HALF_TURN = longint'(1) << (TURN_BITS - 1);
  localparam longint QUARTER   = longint'(1) << (TURN_BITS - 2);
  localparam longint NORM_TOP  = longint'(1) << NORM_BITS;
  localparam longint NORM_BOT  = longint'(1) << (NORM_BITS - 1);
  localparam longint ROUND_BIT = longint'(1) << (TURN_BITS - PHASE_W - 1);

  localparam int FULL_POS = 8388607;
  localparam int FULL_NEG = -8388608;
  localparam real PI_R = 3.14159265358979;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  in_i = '0;
  logic signed [SAMPLE_W-1:0]  in_q = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [PHASE_W-1:0]   phase_delta;

  // arctan(2^-k), 2^32 per turn
  longint arctan_units [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // predictor state: previous sample, and phases still owed by the block
  logic signed [SAMPLE_W-1:0] prev_i = '0;
  logic signed [SAMPLE_W-1:0] prev_q = '0;
  logic signed [PHASE_W-1:0]  phase_q [$];
  logic signed [PHASE_W-1:0]  want_phase;
  int                         error_count = 0;
  idle_mode_t                 idle_mode = IDLE_NONE;

  fm_quadrature_discriminator uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_i        (in_i),
    .in_q        (in_q),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .phase_delta (phase_delta)
  );

  always #4 clk = ~clk;

  // angle of a first-quadrant vector, 2^32 per turn
  function automatic longint vector_angle(input longint mag_x, input longint mag_y);
    longint ux, uy, x, y, z, dx, dy;
    ux = mag_x;
    uy = mag_y;
    if (uy == 0) return 0;
    if (ux == 0) return QUARTER;
    while ((ux > uy ? ux : uy) >= NORM_TOP) begin
      ux = ux >>> 1;
      uy = uy >>> 1;
    end
    while ((ux > uy ? ux : uy) < NORM_BOT) begin
      ux = ux <<< 1;
      uy = uy <<< 1;
    end
    x = ux;
    y = uy;
    z = 0;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += arctan_units[k];
      end else begin
        x -= dx;
        y += dy;
        z -= arctan_units[k];
      end
    end
    return z;
  endfunction

  // phase of cur * conj(old), rounded half up to the output scale
  function automatic logic signed [PHASE_W-1:0] discriminate_phase(
    input longint cur_i, input longint cur_q, input longint old_i, input longint old_q);
    longint re, im, ang, rounded;
    re  = cur_i * old_i + cur_q * old_q;
    im  = cur_q * old_i - cur_i * old_q;
    ang = 0;
    if (re != 0 || im != 0) begin
      ang = vector_angle(re < 0 ? -re : re, im < 0 ? -im : im);
      if (re < 0) ang = HALF_TURN - ang;
      if (im < 0) ang = -ang;
    end
    rounded = (ang + ROUND_BIT) >>> (TURN_BITS - PHASE_W);
    return rounded[PHASE_W-1:0];
  endfunction

  // one input beat; valid is left high so back-to-back beats need no drop
  task automatic send_sample(input int si, input int sq);
    logic signed [SAMPLE_W-1:0] vi;
    logic signed [SAMPLE_W-1:0] vq;
    int                         idle_pct;
    vi       = SAMPLE_W'(si);
    vq       = SAMPLE_W'(sq);
    idle_pct = (idle_mode == IDLE_BOTH) ? 26 : 57;
    while ((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
           $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_i     <= vi;
    in_q     <= vq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    phase_q = {phase_q, discriminate_phase(longint'(vi), longint'(vq),
                                           longint'(prev_i), longint'(prev_q))};
    prev_i = vi;
    prev_q = vq;
  endtask

  // hold off the sender until every owed phase has come back
  task automatic test_drain_pause();
    in_valid <= 1'b0;
    while (phase_q.size() != 0) @(posedge clk);
  endtask

  // zero product, pure real, pure imaginary and the plus-pi wrap
  task automatic test_special_angles();
    idle_mode = IDLE_NONE;
    send_sample(1000, 0);     // first beat after reset: zero product
    send_sample(1000, 0);     // pure real, positive
    send_sample(-1000, 0);    // pure real, negative: pi wraps
    send_sample(0, -1000);    // +pi/2
    send_sample(0, 1000);     // pi again
    send_sample(1000, 0);     // -pi/2
    send_sample(0, 0);        // zero sample
    send_sample(0, 0);
    send_sample(1, 0);
    send_sample(0, 1);
    send_sample(-1, 0);
    send_sample(0, -1);
  endtask

  // full-scale fields and angles either side of pi
  task automatic test_full_scale();
    idle_mode = IDLE_NONE;
    send_sample(FULL_POS, FULL_POS);
    send_sample(FULL_NEG, FULL_NEG);
    send_sample(FULL_NEG, FULL_POS);
    send_sample(FULL_POS, FULL_NEG);
    send_sample(FULL_NEG, FULL_NEG);
    send_sample(FULL_POS, 0);
    send_sample(FULL_NEG, 1);      // just under pi, rounds to the wrap
    send_sample(FULL_POS, 0);
    send_sample(FULL_NEG, 800);    // about one step under pi
    send_sample(FULL_POS, 0);
    send_sample(FULL_NEG, -800);   // about one step over -pi
    send_sample(FULL_POS, 0);
    send_sample(FULL_NEG, -1);
  endtask

  // rotating phasors: tone segments of random rate and level
  task automatic test_fm_tones(input idle_mode_t mode, input int beats);
    real ph, rate, amp;
    int  seg, sent, si, sq;
    idle_mode = mode;
    sent = 0;
    ph   = real'($urandom_range(6283)) / 1000.0;
    while (sent < beats) begin
      rate = (real'($urandom_range(20000)) - 10000.0) / 10000.0 * PI_R;
      if ($urandom_range(3) == 0) amp = real'($urandom_range(255, 1));
      else amp = real'($urandom_range(FULL_POS, 1000000));
      seg = $urandom_range(30, 4);
      for (int n = 0; n < seg && sent < beats; n++) begin
        si = $rtoi(amp * $cos(ph));
        sq = $rtoi(amp * $sin(ph));
        send_sample(si, sq);
        ph += rate;
        sent++;
      end
    end
  endtask

  // unstructured samples: any bit pattern, tiny values, rails and zero
  task automatic test_raw_noise(input idle_mode_t mode, input int beats);
    int ri, rq;
    idle_mode = mode;
    repeat (beats) begin
      case ($urandom_range(3))
        0, 1: begin
          ri = $urandom();
          rq = $urandom();
        end
        2: begin
          ri = int'($urandom_range(15)) - 8;
          rq = int'($urandom_range(15)) - 8;
        end
        default: begin
          case ($urandom_range(2))
            0:       ri = 0;
            1:       ri = FULL_POS;
            default: ri = FULL_NEG;
          endcase
          case ($urandom_range(2))
            0:       rq = 0;
            1:       rq = FULL_POS;
            default: rq = FULL_NEG;
          endcase
        end
      endcase
      send_sample(ri, rq);
    end
  endtask

  // receiver: ready at random while stalling is on
  always @(posedge clk) begin
    if (idle_mode == IDLE_BOTH)
      out_ready <= ($urandom_range(99) >= 26);
    else if (idle_mode == IDLE_RECV)
      out_ready <= ($urandom_range(99) >= 57);
    else
      out_ready <= 1'b1;
  end

  // compare each output beat with the oldest owed phase
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (phase_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual phase_delta %0d",
                 $time, phase_delta);
        error_count++;
      end else begin
        want_phase = phase_q.pop_front();
        if (phase_delta !== want_phase) begin
          $display("%0t: phase_delta mismatch, expected %0d, actual %0d",
                   $time, want_phase, phase_delta);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_special_angles();
    test_full_scale();
    test_drain_pause();
    for (int m = 0; m < 4; m++) begin
      test_fm_tones(idle_mode_t'(m), 90);
      test_raw_noise(idle_mode_t'(m), 30);
      test_drain_pause();
    end
    repeat (60) @(posedge clk);
    if (error_count == 0 && phase_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
